FILE: hw/rtl/wc3_pkg.sv
// Shared types and constants of the 3x3 window convolution block.
package wc3_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 10;
    localparam int SIZE_W    = 11;
    localparam int KERN_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 8;
    localparam int TAPS      = 3;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MIN_SIZE       = 3;
    localparam int WIDTH_RST      = 640;
    localparam int HEIGHT_RST     = 480;
    localparam logic [KERN_W-1:0] KERN_RST = 24'h010101;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_LEFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_RIGHT   = 3'd4;

    // Arithmetic widths: coefficient times zero-extended pixel, then two adder levels.
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int COL_W  = PROD_W + 2;
    localparam int SUM_W  = COL_W + 2;
    localparam int MAG_W  = SUM_W - 1;

    // Division by nine as a multiply by a rounded-up reciprocal; exact for magnitudes
    // below 2**(RECIP_SHIFT - 1).
    localparam int DIVISOR     = 9;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
    localparam int SCALED_W    = MAG_W + RECIP_W;

    typedef logic [TAPS-1:0][TAPS-1:0][PIX_W-1:0] t_window;
    typedef logic [TAPS-1:0][KERN_W-1:0]          t_kernel;

    typedef struct packed {
        logic               vld;
        logic               interior;
        logic               border;
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_meta;

endpackage

FILE: hw/rtl/wc3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wc3_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/wc3_scan.sv
// Raster position counters, the two line buffers and the 3x3 pixel window.
module wc3_scan #(
    parameter int MAX_WIDTH  = wc3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wc3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]  i_width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0] i_height,
    input  logic                              i_adv,
    input  logic                              i_in_valid,
    input  logic [wc3_pkg::PIX_W-1:0]         i_pixel_value,
    output wc3_pkg::t_window                  o_win,
    output wc3_pkg::t_meta                    o_meta
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XCW = $clog2(MAX_WIDTH + 1);
    localparam int YCW = $clog2(MAX_HEIGHT + 1);

    logic [XW-1:0] r_col, n_col;
    logic [YW-1:0] r_row, n_row;

    logic                      accept;
    logic                      col_wrap;
    logic [XW-1:0]             c_eff;
    logic [YCW-1:0]            row_inc;
    logic [YW-1:0]             r_eff;
    logic [XCW-1:0]            c_one;
    logic [YCW-1:0]            row_two;

    logic                      r_s1_vld;
    logic [XW-1:0]             r_s1_col;
    logic [YW-1:0]             r_s1_row;
    logic [wc3_pkg::PIX_W-1:0] r_s1_pix;

    logic [wc3_pkg::PIX_W-1:0] upper_rd;
    logic [wc3_pkg::PIX_W-1:0] middle_rd;
    logic                      line_wr;
    logic                      s1_interior;
    logic                      s1_border;

    wc3_pkg::t_window r_win;
    wc3_pkg::t_meta   r_meta;

    assign accept = i_in_valid && i_adv;

    // Position of the arriving pixel, with wrap when the frame size shrank mid-frame.
    always_comb begin
        col_wrap = XCW'(r_col) >= i_width;
        c_eff    = col_wrap ? '0 : r_col;
        row_inc  = YCW'(r_row) + YCW'(col_wrap);
        r_eff    = (row_inc >= i_height) ? '0 : row_inc[YW-1:0];
        c_one    = XCW'(c_eff) + XCW'(1);
        row_two  = YCW'(r_eff) + YCW'(1);
        if (c_one >= i_width) begin
            n_col = '0;
            n_row = (row_two >= i_height) ? '0 : row_two[YW-1:0];
        end else begin
            n_col = c_one[XW-1:0];
            n_row = r_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_adv) begin
                r_s1_vld <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= c_eff;
            r_s1_row <= r_eff;
            r_s1_pix <= i_pixel_value;
        end
    end

    // The read for a pixel is issued as it is taken; the write back happens as it
    // leaves the first stage, always at a different column than the next read.
    assign line_wr = r_s1_vld && i_adv;

    wc3_ram #(
        .DATA_W (wc3_pkg::PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_upper_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (middle_rd),
        .i_rd_en   (accept),
        .i_rd_addr (c_eff),
        .o_rd_data (upper_rd)
    );

    wc3_ram #(
        .DATA_W (wc3_pkg::PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_middle_line (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_pix),
        .i_rd_en   (accept),
        .i_rd_addr (c_eff),
        .o_rd_data (middle_rd)
    );

    always_comb begin
        s1_interior = (r_s1_col >= XW'(2)) && (r_s1_row >= YW'(2));
        s1_border   = (r_s1_row == '0) || (YCW'(r_s1_row) == i_height - YCW'(1)) ||
                      (r_s1_col == '0) || (XCW'(r_s1_col) == i_width - XCW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_meta.vld <= 1'b0;
        end else if (i_adv) begin
            r_meta.vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= {r_s1_pix, middle_rd, upper_rd};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_meta.interior <= s1_interior;
            r_meta.border   <= s1_border;
            r_meta.pix      <= r_s1_pix;
            r_meta.x        <= wc3_pkg::COORD_W'(r_s1_col);
            r_meta.y        <= wc3_pkg::COORD_W'(r_s1_row);
        end
    end

    assign o_win  = r_win;
    assign o_meta = r_meta;

endmodule

FILE: hw/rtl/wc3_mac.sv
// Nine coefficient products, adder tree and truncating division by nine.
module wc3_mac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  wc3_pkg::t_window          i_win,
    input  wc3_pkg::t_meta            i_meta,
    input  wc3_pkg::t_kernel          i_kern,
    output wc3_pkg::t_meta            o_meta,
    output logic [wc3_pkg::PIX_W-1:0] o_value
);

    localparam int STAGES = 5;

    logic signed [wc3_pkg::PROD_W-1:0] prod [wc3_pkg::TAPS][wc3_pkg::TAPS];
    logic signed [wc3_pkg::PROD_W-1:0] r_prod [wc3_pkg::TAPS][wc3_pkg::TAPS];
    logic signed [wc3_pkg::COL_W-1:0]  r_col_sum [wc3_pkg::TAPS];
    logic signed [wc3_pkg::SUM_W-1:0]  r_sum;
    logic                              r_neg6;
    logic [wc3_pkg::MAG_W-1:0]         r_mag;
    logic                              r_neg7;
    logic [wc3_pkg::SCALED_W-1:0]      r_scaled;
    logic [wc3_pkg::PIX_W-1:0]         quot;

    wc3_pkg::t_meta r_meta [STAGES];

    // Column i of the window meets coefficient register i; row j uses byte j.
    always_comb begin
        for (int i = 0; i < wc3_pkg::TAPS; i++) begin
            for (int j = 0; j < wc3_pkg::TAPS; j++) begin
                prod[i][j] = $signed(i_kern[i][wc3_pkg::COEF_W*j +: wc3_pkg::COEF_W]) *
                             $signed({1'b0, i_win[i][j]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= prod;
            for (int i = 0; i < wc3_pkg::TAPS; i++) begin
                r_col_sum[i] <= wc3_pkg::COL_W'(r_prod[i][0]) +
                                wc3_pkg::COL_W'(r_prod[i][1]) +
                                wc3_pkg::COL_W'(r_prod[i][2]);
            end
            r_sum    <= wc3_pkg::SUM_W'(r_col_sum[0]) + wc3_pkg::SUM_W'(r_col_sum[1]) +
                        wc3_pkg::SUM_W'(r_col_sum[2]);
            r_neg6   <= r_sum[wc3_pkg::SUM_W-1];
            r_mag    <= wc3_pkg::MAG_W'($unsigned(r_sum[wc3_pkg::SUM_W-1] ? -r_sum : r_sum));
            r_neg7   <= r_neg6;
            r_scaled <= wc3_pkg::SCALED_W'(r_mag) *
                        wc3_pkg::SCALED_W'(wc3_pkg::RECIP_MULT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_meta[k].vld <= 1'b0;
            end
        end else if (i_adv) begin
            r_meta[0] <= i_meta;
            for (int k = 1; k < STAGES; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign quot    = r_scaled[wc3_pkg::RECIP_SHIFT +: wc3_pkg::PIX_W];
    assign o_value = r_neg7 ? (wc3_pkg::PIX_W'(0) - quot) : quot;
    assign o_meta  = r_meta[STAGES-1];

endmodule

FILE: hw/rtl/wc3_out.sv
// Result register holding the interior and border results of one pixel.
module wc3_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wc3_pkg::t_meta              i_meta,
    input  logic [wc3_pkg::PIX_W-1:0]   i_value,
    input  logic                        i_out_ready,
    output logic                        o_adv,
    output logic                        o_out_valid,
    output logic [wc3_pkg::COORD_W-1:0] o_out_x,
    output logic [wc3_pkg::COORD_W-1:0] o_out_y,
    output logic [wc3_pkg::PIX_W-1:0]   o_out_value,
    output logic                        o_last
);

    logic                        r_int_vld;
    logic                        r_bor_vld;
    logic [wc3_pkg::COORD_W-1:0] r_int_x, r_int_y, r_bor_x, r_bor_y;
    logic [wc3_pkg::PIX_W-1:0]   r_int_val, r_bor_val;
    logic                        take;

    assign o_out_valid = r_int_vld || r_bor_vld;
    assign take        = o_out_valid && i_out_ready;
    // The pipeline moves when the register is empty or its only result leaves now.
    assign o_adv       = !o_out_valid || (take && (r_int_vld ^ r_bor_vld));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_vld <= 1'b0;
            r_bor_vld <= 1'b0;
        end else if (o_adv) begin
            r_int_vld <= i_meta.vld && i_meta.interior;
            r_bor_vld <= i_meta.vld && i_meta.border;
        end else if (take) begin
            if (r_int_vld) begin
                r_int_vld <= 1'b0;
            end else begin
                r_bor_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_int_x   <= i_meta.x - wc3_pkg::COORD_W'(1);
            r_int_y   <= i_meta.y - wc3_pkg::COORD_W'(1);
            r_int_val <= i_value;
            r_bor_x   <= i_meta.x;
            r_bor_y   <= i_meta.y;
            r_bor_val <= i_meta.pix;
        end
    end

    always_comb begin
        if (r_int_vld) begin
            o_out_x     = r_int_x;
            o_out_y     = r_int_y;
            o_out_value = r_int_val;
            o_last      = !r_bor_vld;
        end else begin
            o_out_x     = r_bor_x;
            o_out_y     = r_bor_y;
            o_out_value = r_bor_val;
            o_last      = 1'b1;
        end
    end

endmodule

FILE: hw/rtl/window_convolution_3x3_top.sv
// 3x3 window convolution over a raster pixel stream: configuration registers and stages.
// A pixel's first result passes the first scan stage, the window register, five MAC stages
// and the result register. Throughput: one pixel per cycle while results are taken; a pixel
// with both an interior and a border result holds the output register while its second
// result is shown. Reset (synchronous, active low) clears the counters, window and valid
// flags and loads 640x480 with an all-ones kernel; line buffer contents are not cleared.
module window_convolution_3x3_top #(
    parameter int MAX_WIDTH  = wc3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wc3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [wc3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wc3_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [wc3_pkg::PIX_W-1:0]     i_pixel_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [wc3_pkg::COORD_W-1:0]   o_out_x,
    output logic [wc3_pkg::COORD_W-1:0]   o_out_y,
    output logic [wc3_pkg::PIX_W-1:0]     o_out_value,
    output logic                          o_last
);

    localparam int XCW = $clog2(MAX_WIDTH + 1);
    localparam int YCW = $clog2(MAX_HEIGHT + 1);
    localparam int XWW = (XCW > wc3_pkg::SIZE_W) ? XCW : wc3_pkg::SIZE_W;
    localparam int YWW = (YCW > wc3_pkg::SIZE_W) ? YCW : wc3_pkg::SIZE_W;
    localparam int WIDTH_INIT  = (wc3_pkg::WIDTH_RST > MAX_WIDTH) ?
                                 MAX_WIDTH : wc3_pkg::WIDTH_RST;
    localparam int HEIGHT_INIT = (wc3_pkg::HEIGHT_RST > MAX_HEIGHT) ?
                                 MAX_HEIGHT : wc3_pkg::HEIGHT_RST;

    logic [XCW-1:0]   r_width, n_width;
    logic [YCW-1:0]   r_height, n_height;
    wc3_pkg::t_kernel r_kern;
    logic [XWW-1:0]   wr_w;
    logic [YWW-1:0]   wr_h;

    logic                      adv;
    wc3_pkg::t_window          win;
    wc3_pkg::t_meta            scan_meta;
    wc3_pkg::t_meta            mac_meta;
    logic [wc3_pkg::PIX_W-1:0] mac_value;

    // Frame sizes are held already limited to the supported range.
    always_comb begin
        wr_w = XWW'(i_cfg_data[wc3_pkg::SIZE_W-1:0]);
        wr_h = YWW'(i_cfg_data[wc3_pkg::SIZE_W-1:0]);
        if (wr_w < XWW'(wc3_pkg::MIN_SIZE)) begin
            n_width = XCW'(wc3_pkg::MIN_SIZE);
        end else if (wr_w > XWW'(MAX_WIDTH)) begin
            n_width = XCW'(MAX_WIDTH);
        end else begin
            n_width = XCW'(wr_w);
        end
        if (wr_h < YWW'(wc3_pkg::MIN_SIZE)) begin
            n_height = YCW'(wc3_pkg::MIN_SIZE);
        end else if (wr_h > YWW'(MAX_HEIGHT)) begin
            n_height = YCW'(MAX_HEIGHT);
        end else begin
            n_height = YCW'(wr_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= XCW'(WIDTH_INIT);
            r_height <= YCW'(HEIGHT_INIT);
            r_kern   <= {wc3_pkg::TAPS{wc3_pkg::KERN_RST}};
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wc3_pkg::REG_FRAME_WIDTH: begin
                    r_width <= n_width;
                end
                wc3_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= n_height;
                end
                wc3_pkg::REG_KERN_LEFT: begin
                    r_kern[0] <= i_cfg_data[wc3_pkg::KERN_W-1:0];
                end
                wc3_pkg::REG_KERN_MIDDLE: begin
                    r_kern[1] <= i_cfg_data[wc3_pkg::KERN_W-1:0];
                end
                wc3_pkg::REG_KERN_RIGHT: begin
                    r_kern[2] <= i_cfg_data[wc3_pkg::KERN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = adv;

    wc3_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_adv         (adv),
        .i_in_valid    (i_in_valid),
        .i_pixel_value (i_pixel_value),
        .o_win         (win),
        .o_meta        (scan_meta)
    );

    wc3_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_win   (win),
        .i_meta  (scan_meta),
        .i_kern  (r_kern),
        .o_meta  (mac_meta),
        .o_value (mac_value)
    );

    wc3_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_meta      (mac_meta),
        .i_value     (mac_value),
        .i_out_ready (i_out_ready),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    // A result that is not the last of its pixel is always followed by another.
    a_not_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |=> o_out_valid)
        else $error("result stream ended after a non-last result");

    // Once the first of two results leaves, the second is shown marked last.
    a_second_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && i_out_ready |=> o_last)
        else $error("second result of a pixel not marked last");

    // A held output stalls the whole pipeline, so no pixel can enter.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while the output is stalled");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

FILE: dv/window_convolution_3x3_top_test.sv
// Self-checking testbench for the 3x3 window convolution block with a pixel-stream tracker.
module window_convolution_3x3_top_test;
    import wc3_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES    = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 1850;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   value;
        logic               last;
    } out_pixel_t;

    // Tracks the frame position, line buffers and window, and holds the pixels still due.
    class conv_tracker;
        logic [SIZE_W-1:0] width_reg;
        logic [SIZE_W-1:0] height_reg;
        logic [KERN_W-1:0] kern [TAPS];
        logic [PIX_W-1:0]  upper_row [MAX_WIDTH_DEF];
        logic [PIX_W-1:0]  middle_row [MAX_WIDTH_DEF];
        logic [PIX_W-1:0]  win [TAPS][TAPS];
        int unsigned       col;
        int unsigned       row;
        out_pixel_t        due_pixels [$];
        int                mismatches;

        function new();
            width_reg  = SIZE_W'(WIDTH_RST);
            height_reg = SIZE_W'(HEIGHT_RST);
            for (int i = 0; i < TAPS; i++) begin
                kern[i] = KERN_RST;
                for (int j = 0; j < TAPS; j++) win[i][j] = '0;
            end
            for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            col        = 0;
            row        = 0;
            mismatches = 0;
        endfunction

        function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg = data[SIZE_W-1:0];
                REG_KERN_LEFT:    kern[0]    = data[KERN_W-1:0];
                REG_KERN_MIDDLE:  kern[1]    = data[KERN_W-1:0];
                REG_KERN_RIGHT:   kern[2]    = data[KERN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return due_pixels.size();
        endfunction

        // Pixels still to send before the current frame is complete.
        function int unsigned pixels_left();
            int unsigned w, h, c, r;
            w = clamp_size(width_reg, MAX_WIDTH_DEF);
            h = clamp_size(height_reg, MAX_HEIGHT_DEF);
            c = col;
            r = row;
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h) r = 0;
            return (h - r) * w - c;
        endfunction

        function void take_pixel(logic [PIX_W-1:0] pix);
            int unsigned w, h, c, r;
            logic [PIX_W-1:0] up, mid;
            int acc, coef;
            out_pixel_t inner, rim;
            bit has_inner, has_rim;
            w = clamp_size(width_reg, MAX_WIDTH_DEF);
            h = clamp_size(height_reg, MAX_HEIGHT_DEF);
            c = col;
            r = row;
            // A position left beyond the frame by a size change wraps to the next row or frame.
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h) r = 0;

            up            = upper_row[c];
            mid           = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = pix;
            for (int i = 0; i < TAPS - 1; i++)
                for (int j = 0; j < TAPS; j++) win[i][j] = win[i+1][j];
            win[2][0] = up;
            win[2][1] = mid;
            win[2][2] = pix;

            has_inner = (c >= 2) && (r >= 2);
            if (has_inner) begin
                acc = 0;
                for (int i = 0; i < TAPS; i++)
                    for (int j = 0; j < TAPS; j++) begin
                        coef = int'($signed(kern[i][COEF_W*j +: COEF_W]));
                        acc += coef * int'(win[i][j]);
                    end
                acc         = acc / DIVISOR;
                inner.x     = COORD_W'(c - 1);
                inner.y     = COORD_W'(r - 1);
                inner.value = acc[PIX_W-1:0];
                inner.last  = 1'b0;
            end
            has_rim = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
            if (has_rim) begin
                rim.x     = COORD_W'(c);
                rim.y     = COORD_W'(r);
                rim.value = pix;
                rim.last  = 1'b1;
            end
            if (has_inner) begin
                inner.last = !has_rim;
                due_pixels.push_back(inner);
            end
            if (has_rim) due_pixels.push_back(rim);

            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col = c;
            row = r;
        endfunction

        function void match_output(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [PIX_W-1:0] value, logic last);
            out_pixel_t got, want;
            got = {x, y, value, last};
            if (due_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output x=%0d y=%0d value=%0d last=%0d",
                             x, y, value, last);
            end else begin
                want = due_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected x=%0d y=%0d value=%0d last=%0d, got x=%0d y=%0d value=%0d last=%0d",
                                 want.x, want.y, want.value, want.last, x, y, value, last);
                end
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel     = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic [PIX_W-1:0]     out_value;
    logic                 out_last;

    bit                   calm = 1'b0;
    int                   stall_cycles = 0;
    conv_tracker          tracker;

    window_convolution_3x3_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_pixel_value (pixel),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_x       (out_x),
        .o_out_y       (out_y),
        .o_out_value   (out_value),
        .o_last        (out_last)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            tracker.match_output(out_x, out_y, out_value, out_last);
    end

    // Ends the run when no transaction has moved on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= pix;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_pixel(pix);
    endtask

    // Pixels that produce no output may still be in the pipeline when the queue drains.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_size();
        int unsigned u;
        u = $urandom_range(99);
        if (u < 5) return CFG_W'($urandom_range(2));
        if (u < 8) return CFG_W'($urandom_range(2047, 1025));
        if (u < 10) return CFG_W'(MAX_WIDTH_DEF);
        if (u < 25) return CFG_W'($urandom_range(48, 13));
        return CFG_W'($urandom_range(12, 3));
    endfunction

    function automatic logic [CFG_W-1:0] rand_kernel();
        logic [KERN_W-1:0] k;
        for (int j = 0; j < TAPS; j++) begin
            case ($urandom_range(7))
                0: k[COEF_W*j +: COEF_W] = 8'h80;
                1: k[COEF_W*j +: COEF_W] = 8'h7f;
                2: k[COEF_W*j +: COEF_W] = 8'h00;
                3: k[COEF_W*j +: COEF_W] = 8'h01;
                4: k[COEF_W*j +: COEF_W] = 8'hff;
                default: k[COEF_W*j +: COEF_W] = COEF_W'($urandom_range(255));
            endcase
        end
        return k;
    endfunction

    initial begin
        int unsigned n;
        int unsigned sent;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sizes below the minimum saturate to 3x3; largest positive coefficients on white.
        write_reg(REG_FRAME_WIDTH, CFG_W'(0));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        write_reg(REG_KERN_LEFT, 24'h7f7f7f);
        write_reg(REG_KERN_MIDDLE, 24'h7f7f7f);
        write_reg(REG_KERN_RIGHT, 24'h7f7f7f);
        cfg_wr_en <= 1'b0;
        repeat (9) send_pixel(8'hff);
        wait_idle();

        // Most negative coefficients with -1 at the centre, so the quotient truncates toward zero from below.
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        write_reg(REG_KERN_LEFT, 24'h808080);
        write_reg(REG_KERN_MIDDLE, 24'h80ff80);
        write_reg(REG_KERN_RIGHT, 24'h808080);
        cfg_wr_en <= 1'b0;
        for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'hff : 8'h00);
        wait_idle();

        // A full-width frame writes every line entry, so later width changes are safe.
        write_reg(REG_FRAME_WIDTH, CFG_W'(2047));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        write_reg(REG_KERN_LEFT, rand_kernel());
        write_reg(REG_KERN_MIDDLE, rand_kernel());
        write_reg(REG_KERN_RIGHT, rand_kernel());
        cfg_wr_en <= 1'b0;
        calm = 1'b1;
        n = tracker.pixels_left();
        repeat (n) send_pixel(rand_pixel());
        wait_idle();
        calm = 1'b0;

        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(2047));
        write_reg(REG_KERN_MIDDLE, rand_kernel());
        cfg_wr_en <= 1'b0;
        n = tracker.pixels_left();
        repeat (n) send_pixel(rand_pixel());
        wait_idle();

        // Mostly whole frames; the partial ones leave a frame open across a size change.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(99) < 60) write_reg(REG_FRAME_WIDTH, rand_size());
            if ($urandom_range(99) < 50) write_reg(REG_FRAME_HEIGHT, rand_size());
            if ($urandom_range(99) < 35) write_reg(REG_KERN_LEFT, rand_kernel());
            if ($urandom_range(99) < 35) write_reg(REG_KERN_MIDDLE, rand_kernel());
            if ($urandom_range(99) < 35) write_reg(REG_KERN_RIGHT, rand_kernel());
            cfg_wr_en <= 1'b0;
            n = tracker.pixels_left();
            if (n > 300 || $urandom_range(99) < 35) n = $urandom_range(40, 1);
            repeat (n) send_pixel(rand_pixel());
            sent += n;
            wait_idle();
        end

        repeat (END_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
